// ----- rtl/xxh32_pkg.sv -----
// ----------------------------------------------------------------------------
// xxh32_pkg
// Shared constants, control word layout and microprogram of the xxHash32
// stream hasher.
// ----------------------------------------------------------------------------
package xxh32_pkg;

    localparam logic [31:0] PRIME1 = 32'h9E3779B1;
    localparam logic [31:0] PRIME2 = 32'h85EBCA77;
    localparam logic [31:0] PRIME3 = 32'hC2B2AE3D;
    localparam logic [31:0] PRIME4 = 32'h27D4EB2F;
    localparam logic [31:0] PRIME5 = 32'h165667B1;

    // seed-zero lane start values
    localparam logic [31:0] LANE_INIT0 = PRIME1 + PRIME2;
    localparam logic [31:0] LANE_INIT1 = PRIME2;
    localparam logic [31:0] LANE_INIT2 = 32'd0;
    localparam logic [31:0] LANE_INIT3 = 32'd0 - PRIME1;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    // program entry points and jump targets
    localparam step_t STEP_WORD  = 4'd0;
    localparam step_t STEP_FIN   = 4'd3;
    localparam step_t STEP_TAIL  = 4'd5;
    localparam step_t STEP_BCHK  = 4'd7;
    localparam step_t STEP_BYTE  = 4'd8;
    localparam step_t STEP_AVAL  = 4'd10;
    localparam step_t STEP_LAST  = 4'd12;

    typedef enum logic [2:0] {
        A_WORD,
        A_LANE,
        A_BUF,
        A_BYTE,
        A_H
    } opnd_sel_t;

    typedef enum logic [2:0] {
        K_P1,
        K_P2,
        K_P3,
        K_P4,
        K_P5
    } prime_sel_t;

    typedef enum logic [1:0] {
        D_NONE,
        D_PROD,
        D_H
    } mul_dst_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_TAKE,
        ACT_CONV0,
        ACT_CONV1,
        ACT_WORD_NEXT,
        ACT_BYTE_NEXT,
        ACT_EMIT
    } act_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_END,
        C_LAST,
        C_WORDS_EMPTY,
        C_WORDS_MORE,
        C_BYTES_EMPTY,
        C_BYTES_MORE
    } cond_t;

    typedef struct packed {
        opnd_sel_t  asel;
        logic       add_prod;
        logic [4:0] rot;
        logic [4:0] xsh;
        prime_sel_t ksel;
        mul_dst_t   dst;
        act_t       act;
        cond_t      cond;
        step_t      target;
    } ctl_t;

    typedef struct packed {
        logic take;
        logic last;
        logic words_empty;
        logic words_more;
        logic bytes_empty;
        logic bytes_more;
        logic out_full;
    } status_t;

    localparam ctl_t CTL_NOP = '{
        asel: A_WORD, add_prod: 1'b0, rot: 5'd0, xsh: 5'd0, ksel: K_P1,
        dst: D_NONE, act: ACT_NONE, cond: C_NEXT, target: STEP_WORD
    };

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
        logic [63:0] d;
        d = {x, x} << r;
        return d[63:32];
    endfunction

    function automatic logic [31:0] prime_val(input prime_sel_t k);
        logic [31:0] v;
        case (k)
            K_P1:    v = PRIME1;
            K_P2:    v = PRIME2;
            K_P3:    v = PRIME3;
            K_P4:    v = PRIME4;
            K_P5:    v = PRIME5;
            default: v = PRIME1;
        endcase
        return v;
    endfunction

    // microprogram: one control word per step
    function automatic ctl_t prog_rom(input step_t s);
        ctl_t c;
        c = CTL_NOP;
        case (s)
            // word round: prod = w*P2, then rotl13(lane+prod)*P1, then commit
            4'd0:
            begin
                c.asel = A_WORD; c.ksel = K_P2; c.dst = D_PROD;
            end
            4'd1:
            begin
                c.asel = A_LANE; c.add_prod = 1'b1; c.rot = 5'd13;
                c.ksel = K_P1; c.dst = D_PROD;
            end
            4'd2:
            begin
                c.act = ACT_TAKE; c.cond = C_LAST; c.target = STEP_FIN;
            end
            // converge lanes or small-input start, add length
            4'd3:
            begin
                c.act = ACT_CONV0;
            end
            4'd4:
            begin
                c.act = ACT_CONV1; c.cond = C_WORDS_EMPTY; c.target = STEP_BCHK;
            end
            // remaining whole words
            4'd5:
            begin
                c.asel = A_BUF; c.ksel = K_P3; c.dst = D_PROD;
            end
            4'd6:
            begin
                c.asel = A_H; c.add_prod = 1'b1; c.rot = 5'd17; c.ksel = K_P4;
                c.dst = D_H; c.act = ACT_WORD_NEXT;
                c.cond = C_WORDS_MORE; c.target = STEP_TAIL;
            end
            // remaining bytes
            4'd7:
            begin
                c.cond = C_BYTES_EMPTY; c.target = STEP_AVAL;
            end
            4'd8:
            begin
                c.asel = A_BYTE; c.ksel = K_P5; c.dst = D_PROD;
            end
            4'd9:
            begin
                c.asel = A_H; c.add_prod = 1'b1; c.rot = 5'd11; c.ksel = K_P1;
                c.dst = D_H; c.act = ACT_BYTE_NEXT;
                c.cond = C_BYTES_MORE; c.target = STEP_BYTE;
            end
            // avalanche
            4'd10:
            begin
                c.asel = A_H; c.xsh = 5'd15; c.ksel = K_P2; c.dst = D_H;
            end
            4'd11:
            begin
                c.asel = A_H; c.xsh = 5'd13; c.ksel = K_P3; c.dst = D_H;
            end
            4'd12:
            begin
                c.act = ACT_EMIT; c.cond = C_END;
            end
            default:
            begin
                c.cond = C_END;
            end
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/xxh32_seq.sv -----
// ----------------------------------------------------------------------------
// xxh32_seq
// Step counter and program ROM: one control word per cycle unless the emit
// step waits on a full output; conditional jumps follow datapath status.
// ----------------------------------------------------------------------------
module xxh32_seq
    import xxh32_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t st,
    output ctl_t    ctl,
    output logic    run,
    output logic    busy
);

    step_t pc_reg;
    step_t pc_next;
    logic  busy_reg;
    logic  busy_next;
    step_t pc_inc;

    // fetch the control word of the current step
    assign ctl    = prog_rom(pc_reg);
    assign pc_inc = pc_reg + step_t'(1);
    assign busy   = busy_reg;

    // hold the emit step while the output register is still full
    assign run = busy_reg && !((ctl.act == ACT_EMIT) && st.out_full);

    // pick the next step
    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (start)
        begin
            busy_next = 1'b1;
            pc_next   = st.take ? STEP_WORD : STEP_FIN;
        end
        else if (run)
        begin
            case (ctl.cond)
                C_NEXT:        pc_next = pc_inc;
                C_END:         busy_next = 1'b0;
                C_LAST:
                begin
                    if (st.last)
                        pc_next = ctl.target;
                    else
                        busy_next = 1'b0;
                end
                C_WORDS_EMPTY: pc_next = st.words_empty ? ctl.target : pc_inc;
                C_WORDS_MORE:  pc_next = st.words_more  ? ctl.target : pc_inc;
                C_BYTES_EMPTY: pc_next = st.bytes_empty ? ctl.target : pc_inc;
                C_BYTES_MORE:  pc_next = st.bytes_more  ? ctl.target : pc_inc;
                default:       busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= STEP_WORD;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

    // program counter never leaves the program while running
    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg <= STEP_LAST))
        else $error("sequencer step outside program");

endmodule

// ----- rtl/xxh32_dp.sv -----
// ----------------------------------------------------------------------------
// xxh32_dp
// Datapath: lane accumulators, stripe buffer, length counter, hash scratch
// register and the shared 32x32 multiplier, driven by the control word.
// ----------------------------------------------------------------------------
module xxh32_dp
    import xxh32_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        last,
    input  logic        run,
    input  ctl_t        ctl,
    input  logic        out_stall,
    output status_t     st,
    output logic [31:0] hash_value,
    output logic        out_valid
);

    logic [31:0] lane_reg [4];
    logic [31:0] lane_next [4];
    logic [31:0] stg_reg [3];
    logic [31:0] stg_next [3];
    logic [31:0] buf_reg [3];
    logic [31:0] buf_next [3];
    logic [1:0]  bufcnt_reg, bufcnt_next;
    logic [31:0] total_reg, total_next;
    logic        seen_reg, seen_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] prod_reg, prod_next;
    logic [31:0] word_reg, word_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        last_reg, last_next;
    logic [1:0]  idx_reg, idx_next;
    logic [31:0] hash_reg, hash_next;
    logic        outv_reg, outv_next;

    logic [2:0]  cnt_sat;
    logic        take_in;
    logic [31:0] opa;
    logic [31:0] opsum;
    logic [31:0] oprot;
    logic [31:0] mopnd;
    logic [31:0] mul_lo;
    logic [1:0]  idx_inc;

    // clamp byte count; a non-final transaction is always a whole word
    assign cnt_sat = (byte_count > 3'd4) ? 3'd4 : byte_count;
    assign take_in = !last || (cnt_sat == 3'd4);
    assign idx_inc = idx_reg + 2'd1;

    // select and shape the multiplier operand
    always_comb
    begin
        case (ctl.asel)
            A_WORD:  opa = word_reg;
            A_LANE:  opa = lane_reg[bufcnt_reg];
            A_BUF:   opa = buf_reg[idx_reg];
            A_BYTE:  opa = {24'd0, word_reg[7:0]};
            A_H:     opa = h_reg;
            default: opa = word_reg;
        endcase
        opsum = opa + (ctl.add_prod ? prod_reg : 32'd0);
        oprot = rotl32(opsum, ctl.rot);
        mopnd = (ctl.xsh == 5'd0) ? oprot : (oprot ^ (oprot >> ctl.xsh));
    end

    // shared multiplier, low half only
    assign mul_lo = mopnd * prime_val(ctl.ksel);

    // next-state logic
    always_comb
    begin
        lane_next   = lane_reg;
        stg_next    = stg_reg;
        buf_next    = buf_reg;
        bufcnt_next = bufcnt_reg;
        total_next  = total_reg;
        seen_next   = seen_reg;
        h_next      = h_reg;
        prod_next   = prod_reg;
        word_next   = word_reg;
        cnt_next    = cnt_reg;
        last_next   = last_reg;
        idx_next    = idx_reg;
        hash_next   = hash_reg;
        outv_next   = outv_reg;

        // drop the result once the receiver takes it
        if (outv_reg && !out_stall)
            outv_next = 1'b0;

        // load a new input transaction
        if (accept)
        begin
            word_next = data_word;
            last_next = last;
            cnt_next  = take_in ? 3'd0 : cnt_sat;
            idx_next  = 2'd0;
            if (!take_in)
                total_next = total_reg + {29'd0, cnt_sat};
        end

        if (run)
        begin
            case (ctl.dst)
                D_PROD:  prod_next = mul_lo;
                D_H:     h_next    = mul_lo;
                default: ;
            endcase

            case (ctl.act)
                ACT_TAKE:
                begin
                    total_next = total_reg + 32'd4;
                    if (bufcnt_reg != 2'd3)
                    begin
                        // park the lane result until its stripe completes
                        stg_next[bufcnt_reg] = prod_reg;
                        buf_next[bufcnt_reg] = word_reg;
                        bufcnt_next          = bufcnt_reg + 2'd1;
                    end
                    else
                    begin
                        lane_next[0] = stg_reg[0];
                        lane_next[1] = stg_reg[1];
                        lane_next[2] = stg_reg[2];
                        lane_next[3] = prod_reg;
                        bufcnt_next  = 2'd0;
                        seen_next    = 1'b1;
                    end
                end
                ACT_CONV0:
                begin
                    h_next = seen_reg ? (rotl32(lane_reg[0], 5'd1) + rotl32(lane_reg[1], 5'd7))
                                      : PRIME5;
                end
                ACT_CONV1:
                begin
                    h_next = h_reg + total_reg
                           + (seen_reg ? (rotl32(lane_reg[2], 5'd12)
                                          + rotl32(lane_reg[3], 5'd18)) : 32'd0);
                end
                ACT_WORD_NEXT:
                begin
                    idx_next = idx_inc;
                end
                ACT_BYTE_NEXT:
                begin
                    word_next = word_reg >> 8;
                    cnt_next  = cnt_reg - 3'd1;
                end
                ACT_EMIT:
                begin
                    hash_next    = h_reg ^ (h_reg >> 16);
                    outv_next    = 1'b1;
                    lane_next[0] = LANE_INIT0;
                    lane_next[1] = LANE_INIT1;
                    lane_next[2] = LANE_INIT2;
                    lane_next[3] = LANE_INIT3;
                    bufcnt_next  = 2'd0;
                    total_next   = 32'd0;
                    seen_next    = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg[0] <= LANE_INIT0;
            lane_reg[1] <= LANE_INIT1;
            lane_reg[2] <= LANE_INIT2;
            lane_reg[3] <= LANE_INIT3;
            bufcnt_reg  <= 2'd0;
            total_reg   <= 32'd0;
            seen_reg    <= 1'b0;
            cnt_reg     <= 3'd0;
            last_reg    <= 1'b0;
            idx_reg     <= 2'd0;
            outv_reg    <= 1'b0;
        end
        else
        begin
            lane_reg   <= lane_next;
            bufcnt_reg <= bufcnt_next;
            total_reg  <= total_next;
            seen_reg   <= seen_next;
            cnt_reg    <= cnt_next;
            last_reg   <= last_next;
            idx_reg    <= idx_next;
            outv_reg   <= outv_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        stg_reg  <= stg_next;
        buf_reg  <= buf_next;
        h_reg    <= h_next;
        prod_reg <= prod_next;
        word_reg <= word_next;
        hash_reg <= hash_next;
    end

    // status to the sequencer
    assign st.take        = take_in;
    assign st.last        = last_reg;
    assign st.words_empty = (bufcnt_reg == 2'd0);
    assign st.words_more  = (idx_inc != bufcnt_reg);
    assign st.bytes_empty = (cnt_reg == 3'd0);
    assign st.bytes_more  = (cnt_reg != 3'd1);
    assign st.out_full    = outv_reg && out_stall;

    assign hash_value = hash_reg;
    assign out_valid  = outv_reg;

endmodule

// ----- rtl/xxh32_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// xxhash32_stream_hasher
// Seed-zero xxHash32 over a stream of little-endian 32-bit words.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one transaction per message word with
// data_word, byte_count and last. Non-final words always count as 4 bytes;
// the final word carries 0 to 4 bytes (counts above 4 count as 4).
// Output channel (out_valid / out_stall): one hash_value per message.
// A microcoded sequencer drives one shared 32x32 multiplier. A non-final
// word is accepted and then runs three program steps (two multiplies and
// a commit); the next word is taken only after the commit.
// The final transaction runs the finish program: a word round for a whole
// last word, convergence and length, a multiply round per buffered word
// (0-3), a byte check, a multiply round per trailing byte (0-3), then
// avalanche and output.
// in_stall is high while a program runs. The output sits in a register; if
// the receiver stalls, the next message proceeds and only its final output
// step waits until that register is free.
// Reset returns lanes, length and counters to the seed-zero start state.
// ----------------------------------------------------------------------------
module xxhash32_stream_hasher
    import xxh32_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] hash_value
);

    logic    accept;
    logic    busy;
    logic    run;
    ctl_t    ctl;
    status_t st;

    // take a transaction only while no program runs
    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    xxh32_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .st    (st),
        .ctl   (ctl),
        .run   (run),
        .busy  (busy)
    );

    xxh32_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_word  (data_word),
        .byte_count (byte_count),
        .last       (last),
        .run        (run),
        .ctl        (ctl),
        .out_stall  (out_stall),
        .st         (st),
        .hash_value (hash_value),
        .out_valid  (out_valid)
    );

    // a result appears only from the emit step
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(run && (ctl.act == ACT_EMIT)))
        else $error("output valid without emit step");

    // an accepted transaction always starts a program
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("accepted transaction did not start the sequencer");

endmodule
